### rtl/core/dprd_pkg.sv
`default_nettype none

package dprd_pkg;

	// Pads in result order: orange, red, yellow, green, blue, bass, hi-hat.
	localparam int PAD_COUNT = 7;
	localparam int PAD_BASS  = 5;
	localparam int PAD_HIHAT = 6;

	typedef logic [2:0] level_t;
	typedef logic [4:0] pad_code_t;
	typedef logic [5:0] stick_t;

	localparam pad_code_t PAD_CODE [PAD_COUNT] = '{
		5'h0e, 5'h19, 5'h11, 5'h12, 5'h0f, 5'h1b, 5'h0e
	};

	localparam level_t DEFAULT_PRESSURE_RST = 3'd3;
	localparam stick_t STICK_CENTER         = 6'h20;

	// Bit positions inside the report bytes.
	localparam int HIHAT_FLAG_BIT  = 7;
	localparam int NO_PRESS_BIT    = 6;
	localparam int MINUS_BTN_BIT   = 4;
	localparam int PLUS_BTN_BIT    = 2;
	localparam int FIRST_PAD_BIT   = 7;

	// Hit information that every pad slot compares against.
	typedef struct packed {
		logic      no_press;
		pad_code_t code;
		level_t    level;
	} hit_t;

endpackage

`default_nettype wire

### rtl/core/dprd_report_if.sv
`default_nettype none

interface dprd_report_if;
	logic       valid;
	logic       ready;
	logic [7:0] report_byte_0;
	logic [7:0] report_byte_1;
	logic [7:0] report_byte_2;
	logic [7:0] report_byte_3;
	logic [7:0] report_byte_4;
	logic [7:0] report_byte_5;

	modport source (
		output valid, report_byte_0, report_byte_1, report_byte_2,
		output report_byte_3, report_byte_4, report_byte_5,
		input  ready
	);
	modport sink (
		input  valid, report_byte_0, report_byte_1, report_byte_2,
		input  report_byte_3, report_byte_4, report_byte_5,
		output ready
	);
endinterface

`default_nettype wire

### rtl/core/dprd_result_if.sv
`default_nettype none

interface dprd_result_if;
	logic              valid;
	logic              ready;
	logic signed [5:0] stick_x;
	logic signed [5:0] stick_y;
	logic              start_pressed;
	logic              select_pressed;
	logic [2:0]        cymbal_right_level;
	logic [2:0]        tom_left_level;
	logic [2:0]        cymbal_left_level;
	logic [2:0]        tom_far_right_level;
	logic [2:0]        tom_right_level;
	logic [2:0]        bass_level;
	logic [2:0]        hi_hat_level;
	logic [6:0]        update_mask;

	modport source (
		output valid, stick_x, stick_y, start_pressed, select_pressed,
		output cymbal_right_level, tom_left_level, cymbal_left_level,
		output tom_far_right_level, tom_right_level, bass_level, hi_hat_level,
		output update_mask,
		input  ready
	);
	modport sink (
		input  valid, stick_x, stick_y, start_pressed, select_pressed,
		input  cymbal_right_level, tom_left_level, cymbal_left_level,
		input  tom_far_right_level, tom_right_level, bass_level, hi_hat_level,
		input  update_mask,
		output ready
	);
endinterface

`default_nettype wire

### rtl/core/dprd_pad_slot.sv
`default_nettype none

// Next-level decision for one pad: a code match wins, otherwise the level
// follows the on/off bit when the two disagree.
module dprd_pad_slot (
	input  wire dprd_pkg::hit_t      hit,
	input  wire                      match_en,
	input  wire dprd_pkg::pad_code_t pad_code,
	input  wire                      pad_on,
	input  wire dprd_pkg::level_t    cur_level,
	input  wire dprd_pkg::level_t    default_level,
	output dprd_pkg::level_t         next_level,
	output logic                     rewrite
);

	logic code_hit;
	logic is_lit;

	assign code_hit = match_en && !hit.no_press && (hit.code == pad_code);
	assign is_lit   = (cur_level != '0);

	always_comb begin
		next_level = cur_level;
		rewrite    = 1'b0;
		if (code_hit) begin
			next_level = hit.level;
			rewrite    = 1'b1;
		end else if (pad_on != is_lit) begin
			next_level = pad_on ? default_level : '0;
			rewrite    = 1'b1;
		end
	end

endmodule

`default_nettype wire

### rtl/core/drum_pad_report_decoder_core.sv
// Drum pad report decoder. Each six-byte drum extension report word taken on
// the report channel yields exactly one result word: the re-centered stick,
// the start and select buttons, the stored pressure of all seven pads after
// this report, and a mask of the pads that this report rewrote. The block
// takes one report per clock cycle unless the report channel stalls. A
// report is decoded into an input register in the cycle after it is taken,
// and the pad update and result register load follow when the word moves
// on; that move waits while the result side is stalled. The seven pad levels
// are written at the same edge as the result register, which is what lets a
// report in the next cycle see them at once. The result register and the
// input register act as two slots, so a report is still accepted while a
// finished result waits; the report channel stalls only when both slots are
// full. The default pressure register (cfg_we, cfg_wdata) is meant to be
// written only while no report is in flight; it resets to three, and all
// pad levels reset to zero.
`default_nettype none

module drum_pad_report_decoder_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire [2:0]           cfg_wdata,
	dprd_report_if.sink         report,
	dprd_result_if.source       result
);

	localparam int N = dprd_pkg::PAD_COUNT;

	// Configuration register.
	dprd_pkg::level_t default_level_q;

	// Decoded report, first stage.
	logic             valid_s1;
	dprd_pkg::stick_t stick_x_s1;
	dprd_pkg::stick_t stick_y_s1;
	logic             start_s1;
	logic             select_s1;
	dprd_pkg::hit_t   hit_s1;
	logic             hihat_s1;
	logic [N-1:0]     pad_on_s1;

	// Result register and stored pad levels.
	logic             valid_s2;
	dprd_pkg::stick_t stick_x_s2;
	dprd_pkg::stick_t stick_y_s2;
	logic             start_s2;
	logic             select_s2;
	logic [N-1:0]     mask_s2;
	dprd_pkg::level_t pad_level_q [N];

	// Per-pad next levels from the slot logic.
	dprd_pkg::level_t next_level [N];
	logic [N-1:0]     rewrite;
	logic [N-1:0]     match_en;

	logic advance;
	logic take;

	// The second stage moves whenever the result register is empty or drained.
	assign advance      = !valid_s2 || result.ready;
	assign report.ready = !valid_s1 || advance;
	assign take         = report.valid && report.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_level_q <= dprd_pkg::DEFAULT_PRESSURE_RST;
		end else if (cfg_we) begin
			default_level_q <= cfg_wdata;
		end
	end

	// First stage: pick the fields out of the report bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (report.ready) begin
			valid_s1 <= report.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			// Subtracting thirty-two in six bits just flips the top bit.
			stick_x_s1     <= report.report_byte_0[5:0] ^ dprd_pkg::STICK_CENTER;
			stick_y_s1     <= report.report_byte_1[5:0] ^ dprd_pkg::STICK_CENTER;
			start_s1       <= !report.report_byte_4[dprd_pkg::PLUS_BTN_BIT];
			select_s1      <= !report.report_byte_4[dprd_pkg::MINUS_BTN_BIT];
			hit_s1.no_press <= report.report_byte_2[dprd_pkg::NO_PRESS_BIT];
			hit_s1.code    <= report.report_byte_2[5:1];
			// Pressure is seven minus the inverted softness, which is its complement.
			hit_s1.level   <= ~report.report_byte_3[7:5];
			hihat_s1       <= !report.report_byte_2[dprd_pkg::HIHAT_FLAG_BIT];
			// Pad switches are active low, orange at the top bit. The hi-hat has
			// no switch and always reads as off.
			for (int i = 0; i < N; i++) begin
				if (i == dprd_pkg::PAD_HIHAT) begin
					pad_on_s1[i] <= 1'b0;
				end else begin
					pad_on_s1[i] <= !report.report_byte_5[dprd_pkg::FIRST_PAD_BIT - i];
				end
			end
		end
	end

	// The bass and the hi-hat share the code slot chosen by the hi-hat flag.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			if (i == dprd_pkg::PAD_BASS) begin
				match_en[i] = !hihat_s1;
			end else if (i == dprd_pkg::PAD_HIHAT) begin
				match_en[i] = hihat_s1;
			end else begin
				match_en[i] = 1'b1;
			end
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_slot
		dprd_pad_slot u_slot (
			.hit           (hit_s1),
			.match_en      (match_en[g]),
			.pad_code      (dprd_pkg::PAD_CODE[g]),
			.pad_on        (pad_on_s1[g]),
			.cur_level     (pad_level_q[g]),
			.default_level (default_level_q),
			.next_level    (next_level[g]),
			.rewrite       (rewrite[g])
		);
	end

	// Second stage: pad levels change only when a word moves into the result
	// register, so the next word in the first stage sees them right away.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			for (int i = 0; i < N; i++) begin
				pad_level_q[i] <= '0;
			end
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				for (int i = 0; i < N; i++) begin
					pad_level_q[i] <= next_level[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			stick_x_s2 <= stick_x_s1;
			stick_y_s2 <= stick_y_s1;
			start_s2   <= start_s1;
			select_s2  <= select_s1;
			mask_s2    <= rewrite;
		end
	end

	// The stored levels only move together with the result register, so they
	// always match the word on display.
	assign result.valid               = valid_s2;
	assign result.stick_x             = $signed(stick_x_s2);
	assign result.stick_y             = $signed(stick_y_s2);
	assign result.start_pressed       = start_s2;
	assign result.select_pressed      = select_s2;
	assign result.cymbal_right_level  = pad_level_q[0];
	assign result.tom_left_level      = pad_level_q[1];
	assign result.cymbal_left_level   = pad_level_q[2];
	assign result.tom_far_right_level = pad_level_q[3];
	assign result.tom_right_level     = pad_level_q[4];
	assign result.bass_level          = pad_level_q[dprd_pkg::PAD_BASS];
	assign result.hi_hat_level        = pad_level_q[dprd_pkg::PAD_HIHAT];
	assign result.update_mask         = mask_s2;

endmodule

`default_nettype wire

### rtl/core/dprd_checker.sv
`default_nettype none

module dprd_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       report_valid,
	input wire       report_ready,
	input wire       result_valid,
	input wire       result_ready,
	input wire [2:0] hi_hat_level,
	input wire [6:0] update_mask,
	input wire [5:0] stick_x
);

	// A result word that is not taken stays up.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result word dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(update_mask) && $stable(stick_x))
		else $error("stalled result word changed");

	// The report side stalls only when a finished word is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!report_ready |-> result_valid)
		else $error("report channel stalled with empty result register");

	// The hi-hat is never on, so a nonzero level must have just been written.
	a_hihat_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (hi_hat_level != 3'd0) |-> update_mask[6])
		else $error("hi-hat level held without a rewrite");

endmodule

bind drum_pad_report_decoder_core dprd_checker u_dprd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.report_valid (report.valid),
	.report_ready (report.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.hi_hat_level (result.hi_hat_level),
	.update_mask  (result.update_mask),
	.stick_x      (result.stick_x)
);

`default_nettype wire
